[hw/rtl/smto_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smto_pkg
// Shared types, codes and helpers of the swerve module target optimizer.
// ----------------------------------------------------------------------------
package smto_pkg;

   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DRIVE_MODE        = 3'd0,
      CSR_FORCE_GAIN        = 3'd1,
      CSR_SPEED_DEADBAND    = 3'd2,
      CSR_FORCE_DEADBAND    = 3'd3,
      CSR_CURRENT_DEADBAND  = 3'd4,
      CSR_CURRENT_LIMIT     = 3'd5,
      CSR_STEER_ZERO_OFFSET = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      METHOD_SPEED    = 2'd0,
      METHOD_CURRENT  = 2'd1,
      METHOD_DISABLED = 2'd2
   } method_type;

   localparam logic FUNC_CALC = 1'b0;
   localparam logic FUNC_STOP = 1'b1;

   typedef struct packed {
      logic        drive_mode;
      logic [15:0] force_gain;
      logic [14:0] speed_dead_zone;
      logic [14:0] force_dead_zone;
      logic [18:0] current_dead_zone;
      logic [18:0] current_limit;
      logic [15:0] steer_zero_offset;
   } cfg_type;

   typedef struct packed {
      logic               func;
      logic signed [15:0] target_angle;
      logic signed [15:0] target_velocity;
      logic signed [15:0] target_force;
      logic        [15:0] encoder_angle;
   } req_type;

   // after angle optimization, deadbands and flip
   typedef struct packed {
      logic               configured;
      logic signed [15:0] steer_position;
      logic signed [15:0] steer_feedback;
      method_type         drive_method;
      logic signed [15:0] drive_speed;
      logic signed [15:0] drive_force;
      logic               flipped;
   } prep_type;

   // force times gain, before rounding
   typedef struct packed {
      logic               configured;
      logic signed [15:0] steer_position;
      logic signed [15:0] steer_feedback;
      method_type         drive_method;
      logic signed [15:0] drive_speed;
      logic signed [31:0] product;
      logic               flipped;
   } prod_type;

   typedef struct packed {
      logic               configured;
      logic signed [15:0] steer_position;
      logic signed [15:0] steer_feedback;
      method_type         drive_method;
      logic signed [15:0] drive_speed;
      logic signed [19:0] drive_current;
      logic               flipped;
   } rsp_type;

   // magnitude of a 16-bit value; the most negative value gives 32768
   function automatic logic [15:0] mag16(input logic signed [15:0] x);
      logic [15:0] u;
      u = $unsigned(x);
      return x[15] ? (~u + 16'd1) : u;
   endfunction

   // negate, saturating the most negative value to the most positive
   function automatic logic signed [15:0] neg16(input logic signed [15:0] x);
      logic signed [15:0] r;
      if (x == 16'sh8000) begin
         r = 16'sh7FFF;
      end else begin
         r = -x;
      end
      return r;
   endfunction

endpackage

[hw/rtl/smto_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smto_req_if
// Target channel: one wheel target and encoder reading per transfer.
// ----------------------------------------------------------------------------
interface smto_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [15:0] target_angle;
   logic signed [15:0] target_velocity;
   logic signed [15:0] target_force;
   logic        [15:0] encoder_angle;

   modport source (output valid, func, target_angle, target_velocity, target_force,
                   encoder_angle, input ready);
   modport sink (input valid, func, target_angle, target_velocity, target_force,
                 encoder_angle, output ready);
endinterface

[hw/rtl/smto_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smto_rsp_if
// Result channel: optimized steer and drive targets per transfer.
// ----------------------------------------------------------------------------
interface smto_rsp_if;
   logic               valid;
   logic               ready;
   logic               configured;
   logic signed [15:0] steer_position;
   logic signed [15:0] steer_feedback;
   logic        [1:0]  drive_method;
   logic signed [15:0] drive_speed;
   logic signed [19:0] drive_current;
   logic               flipped;

   modport source (output valid, configured, steer_position, steer_feedback,
                   drive_method, drive_speed, drive_current, flipped, input ready);
   modport sink (input valid, configured, steer_position, steer_feedback,
                 drive_method, drive_speed, drive_current, flipped, output ready);
endinterface

[hw/rtl/smto_csr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smto_csr_if
// Register write channel: register index and write data per transfer.
// ----------------------------------------------------------------------------
interface smto_csr_if import smto_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/smto_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smto_prep
// Stage 1: steer feedback, angle error, half-turn flip and deadbands.
// ----------------------------------------------------------------------------
module smto_prep import smto_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output prep_type out_data
);

   localparam logic        [ANGLE_BITS-1:0] HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};
   localparam logic signed [ANGLE_BITS-1:0] QTR  = {2'b01, {(ANGLE_BITS-2){1'b0}}};
   localparam logic signed [ANGLE_BITS-1:0] NQTR = {2'b11, {(ANGLE_BITS-2){1'b0}}};

   logic                         valid_ff, valid_in;
   prep_type                     data_ff, data_in;
   logic        [ANGLE_BITS-1:0] tgt_w, enc_w, off_w, fb_w, pos_w;
   logic signed [ANGLE_BITS-1:0] err_s;
   logic                         calc, flip;
   logic signed [15:0]           speed_db, force_db;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      tgt_w = ANGLE_BITS'($unsigned(in_data.target_angle));
      enc_w = ANGLE_BITS'(in_data.encoder_angle);
      off_w = ANGLE_BITS'(cfg.steer_zero_offset);
      fb_w  = enc_w - off_w;
      err_s = $signed(tgt_w - fb_w);
      calc  = (in_data.func == FUNC_CALC);
      // an error of exactly minus a half turn flips too
      flip  = calc && ((err_s > QTR) || (err_s < NQTR));
      pos_w = flip ? (tgt_w + HALF) : tgt_w;

      speed_db = (mag16(in_data.target_velocity) < {1'b0, cfg.speed_dead_zone}) ?
                 16'sd0 : in_data.target_velocity;
      force_db = (mag16(in_data.target_force) < {1'b0, cfg.force_dead_zone}) ?
                 16'sd0 : in_data.target_force;

      data_in.configured     = 1'b1;
      data_in.steer_position = $signed(16'(pos_w));
      data_in.steer_feedback = $signed(16'(fb_w));
      data_in.flipped        = flip;
      if (calc) begin
         data_in.drive_method = cfg.drive_mode ? METHOD_CURRENT : METHOD_SPEED;
         data_in.drive_speed  = flip ? neg16(speed_db) : speed_db;
         data_in.drive_force  = flip ? neg16(force_db) : force_db;
      end else begin
         data_in.drive_method = METHOD_DISABLED;
         data_in.drive_speed  = 16'sd0;
         data_in.drive_force  = 16'sd0;
      end

      // unconfigured: every field reads zero
      if (cfg.force_gain == 16'd0) begin
         data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/smto_mult.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smto_mult
// Stage 2: force times Q4.12 gain.
// ----------------------------------------------------------------------------
module smto_mult import smto_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  prep_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output prod_type out_data
);

   logic               valid_ff, valid_in;
   prod_type           data_ff, data_in;
   logic signed [16:0] gain_s;
   logic signed [32:0] prod_full;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      gain_s    = $signed({1'b0, cfg.force_gain});
      prod_full = in_data.drive_force * gain_s;
      data_in.configured     = in_data.configured;
      data_in.steer_position = in_data.steer_position;
      data_in.steer_feedback = in_data.steer_feedback;
      data_in.drive_method   = in_data.drive_method;
      data_in.drive_speed    = in_data.drive_speed;
      // magnitude stays below 2^31, so 32 bits hold the product
      data_in.product        = $signed(prod_full[31:0]);
      data_in.flipped        = in_data.flipped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/smto_shape.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smto_shape
// Stage 3: round to current, saturate, apply current deadband; output register.
// ----------------------------------------------------------------------------
module smto_shape import smto_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_data
);

   logic        valid_ff, valid_in;
   rsp_type     data_ff, data_in;
   logic [31:0] p_u, p_mag, p_sum;
   logic [19:0] q, q_lim, q_db;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      p_u   = $unsigned(in_data.product);
      p_mag = in_data.product[31] ? (~p_u + 32'd1) : p_u;
      // round to nearest, ties away from zero
      p_sum = p_mag + 32'd2048;
      q     = p_sum[31:12];
      q_lim = ((cfg.current_limit != 19'd0) && (q > {1'b0, cfg.current_limit})) ?
              {1'b0, cfg.current_limit} : q;
      q_db  = (q_lim < {1'b0, cfg.current_dead_zone}) ? 20'd0 : q_lim;

      data_in.configured     = in_data.configured;
      data_in.steer_position = in_data.steer_position;
      data_in.steer_feedback = in_data.steer_feedback;
      data_in.drive_method   = in_data.drive_method;
      data_in.drive_speed    = in_data.drive_speed;
      data_in.drive_current  = in_data.product[31] ? $signed(~q_db + 20'd1) :
                                                      $signed(q_db);
      data_in.flipped        = in_data.flipped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

[hw/rtl/swerve_module_target_optimizer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerve_module_target_optimizer_core
// Optimizes one swerve wheel target per transfer against the encoder angle.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries a wheel target (func, angle, speed, force) and the encoder
//   reading; rsp_bus returns one result per target, in order. csr_bus writes
//   the configuration registers by index and is always ready; write only
//   while no target is in flight.
//   rsp valid rises once a req transfer has passed the prep, multiply and
//   round/saturate registers; throughput is one target per cycle while the
//   receiver does not stall, set by these three register stages, each taking
//   a new item every cycle.
//   When the receiver stalls, the result holds in the output stage and the
//   earlier stages keep filling; up to 3 targets are held before req ready
//   drops. Nothing is dropped or repeated.
//   Reset clears all stage valid bits and returns the registers to their
//   reset values: drive_mode 1, all others 0 (block unconfigured).
// ----------------------------------------------------------------------------
module swerve_module_target_optimizer_core import smto_pkg::*; #(
   parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   smto_req_if.sink   req_bus,
   smto_rsp_if.source rsp_bus,
   smto_csr_if.sink   csr_bus
);

   cfg_type  cfg_ff, cfg_in;
   req_type  req_data;
   prep_type prep_data;
   prod_type prod_data;
   rsp_type  rsp_data;
   logic     prep_valid, prep_ready, prod_valid, prod_ready;
   logic     rsp_valid;
   logic [2:0] inflight_ff, inflight_in;

   // configuration registers
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_DRIVE_MODE:        cfg_in.drive_mode        = csr_bus.data[0];
            CSR_FORCE_GAIN:        cfg_in.force_gain        = csr_bus.data[15:0];
            CSR_SPEED_DEADBAND:    cfg_in.speed_dead_zone   = csr_bus.data[14:0];
            CSR_FORCE_DEADBAND:    cfg_in.force_dead_zone   = csr_bus.data[14:0];
            CSR_CURRENT_DEADBAND:  cfg_in.current_dead_zone = csr_bus.data[18:0];
            CSR_CURRENT_LIMIT:     cfg_in.current_limit     = csr_bus.data[18:0];
            CSR_STEER_ZERO_OFFSET: cfg_in.steer_zero_offset = csr_bus.data[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // drive_mode is the top field and resets to 1
         cfg_ff <= cfg_type'({1'b1, {($bits(cfg_type) - 1){1'b0}}});
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_data.func            = req_bus.func;
   assign req_data.target_angle    = req_bus.target_angle;
   assign req_data.target_velocity = req_bus.target_velocity;
   assign req_data.target_force    = req_bus.target_force;
   assign req_data.encoder_angle   = req_bus.encoder_angle;

   smto_prep #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_data),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   smto_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   smto_shape u_shape (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.valid          = rsp_valid;
   assign rsp_bus.configured     = rsp_data.configured;
   assign rsp_bus.steer_position = rsp_data.steer_position;
   assign rsp_bus.steer_feedback = rsp_data.steer_feedback;
   assign rsp_bus.drive_method   = rsp_data.drive_method;
   assign rsp_bus.drive_speed    = rsp_data.drive_speed;
   assign rsp_bus.drive_current  = rsp_data.drive_current;
   assign rsp_bus.flipped        = rsp_data.flipped;

   // items in flight, for checking the stage valid bits
   always_comb begin
      inflight_in = inflight_ff;
      if (req_bus.valid && req_bus.ready) begin
         inflight_in = inflight_in + 3'd1;
      end
      if (rsp_valid && rsp_bus.ready) begin
         inflight_in = inflight_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 3'd0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_inflight_matches_stages: assert property (@(posedge clock) disable iff (reset)
      32'(inflight_ff) == $countones({prep_valid, prod_valid, rsp_valid}))
      else $error("in-flight count disagrees with stage valid bits");

   a_inflight_bounded: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'd3)
      else $error("more items in flight than pipeline stages");

   a_disabled_drive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.drive_method == METHOD_DISABLED) |->
      (rsp_data.drive_speed == 16'sd0) && (rsp_data.drive_current == 20'sd0) &&
      !rsp_data.flipped && rsp_data.configured)
      else $error("stop result carries drive targets");

   a_flip_needs_calc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.flipped |->
      rsp_data.configured && (rsp_data.drive_method != METHOD_DISABLED))
      else $error("flip reported on a stop or unconfigured result");

endmodule
